### design/lcas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared types, selector codes and helpers for the B3/S23 cell engine.
// ----------------------------------------------------------------------------
package lcas_pkg;

   localparam int SIDE_DEFAULT = 64;
   localparam int COORD_W      = 6;
   localparam int QUOT_W       = 5;
   localparam int COUNT_W      = 4;

   // Request selector codes.
   localparam logic [1:0] FUNC_SET  = 2'd0;
   localparam logic [1:0] FUNC_EVAL = 2'd1;
   localparam logic [1:0] FUNC_SWAP = 2'd2;

   // Rule constants: birth on three, survival on two or three.
   localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_LOW = 4'd2;
   localparam logic [COUNT_W-1:0] MAX_COUNT   = 4'd8;

   // Reciprocal of three in 7 fractional bits, exact for values below 128.
   localparam logic [5:0] RECIP3 = 6'd43;

   typedef struct packed {
      logic [1:0]         func;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
   } req_type;

   typedef struct packed {
      logic               alive_now;
      logic               alive_next;
      logic [COUNT_W-1:0] neighbor_count;
   } rsp_type;

   function automatic logic [QUOT_W-1:0] quot3(input logic [COORD_W-1:0] v);
      logic [11:0] prod;
      prod = 12'(v) * 12'(RECIP3);
      return prod[11:7];
   endfunction

   function automatic logic [1:0] rem3(input logic [COORD_W-1:0] v);
      logic [COORD_W-1:0] back;
      back = COORD_W'(quot3(v)) * COORD_W'(3);
      return 2'(v - back);
   endfunction

   function automatic logic [1:0] inc3(input logic [1:0] v);
      return (v == 2'd2) ? 2'd0 : v + 2'd1;
   endfunction

   function automatic logic [1:0] dec3(input logic [1:0] v);
      return (v == 2'd0) ? 2'd2 : v - 2'd1;
   endfunction

endpackage
`default_nettype wire

### design/lcas_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_bank
// One row bank of a board: bit write or whole-row clear, registered row read.
// ----------------------------------------------------------------------------
module lcas_bank #(
   parameter int SIDE  = lcas_pkg::SIDE_DEFAULT,
   parameter int DEPTH = (lcas_pkg::SIDE_DEFAULT + 2) / 3
) (
   input  wire logic                     clock,
   input  wire logic                     wr_clear,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [$clog2(SIDE)-1:0]  wr_bit,
   input  wire logic                     wr_value,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [SIDE-1:0]          rd_data
);

   logic [SIDE-1:0] mem_ff [DEPTH];
   logic [SIDE-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_clear) begin
         mem_ff[wr_addr] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr][wr_bit] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### design/lcas_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_eval
// Neighbor count over a 3x3 window and the B3/S23 successor state.
// ----------------------------------------------------------------------------
module lcas_eval (
   input  wire logic             enable,
   input  wire logic [2:0]       win_up,
   input  wire logic [2:0]       win_mid,
   input  wire logic [2:0]       win_dn,
   output lcas_pkg::rsp_type     rsp
);

   logic [lcas_pkg::COUNT_W-1:0] count;
   logic                         now;
   logic                         nxt;

   // The center of the middle row is the cell itself and is not counted.
   assign count = 4'(win_up[0]) + 4'(win_up[1]) + 4'(win_up[2])
                + 4'(win_mid[0]) + 4'(win_mid[2])
                + 4'(win_dn[0]) + 4'(win_dn[1]) + 4'(win_dn[2]);
   assign now = win_mid[1];
   assign nxt = now ? ((count == lcas_pkg::SURVIVE_LOW) || (count == lcas_pkg::BIRTH_COUNT))
                    : (count == lcas_pkg::BIRTH_COUNT);

   always_comb begin
      rsp = '0;
      if (enable) begin
         rsp.alive_now      = now;
         rsp.alive_next     = nxt;
         rsp.neighbor_count = count;
      end
   end

endmodule
`default_nettype wire

### design/life_cell_automaton_step_top.sv
`default_nettype none
// Timing: a transaction accepted at a clock edge has its result on rsp_data with
// rsp_strobe high during the cycle after the next edge (read stage, then result register).
// Throughput: one transaction per cycle while busy is low; each board row bank has one read
// and one write port. Reset: busy stays high while both boards are cleared one bank row per
// cycle over all DEPTH = ceil(SIDE/3) bank rows (22 at SIDE = 64). The receiver cannot stall results.
// ----------------------------------------------------------------------------
// life_cell_automaton_step_top
// Double-buffered B3/S23 cell engine: set, evaluate and swap transactions.
// ----------------------------------------------------------------------------
module life_cell_automaton_step_top #(
   parameter int SIDE = lcas_pkg::SIDE_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lcas_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output lcas_pkg::rsp_type      rsp_data
);

   localparam int DEPTH = (SIDE + 2) / 3;
   localparam int BAW   = $clog2(DEPTH);
   localparam int CAW   = $clog2(SIDE);
   localparam logic [8:0] SIDE_V = 9'(SIDE);
   localparam logic [BAW-1:0] LAST_ROW = BAW'(DEPTH - 1);

   // Rows are spread over three banks by row mod 3, so the three rows around
   // a cell always sit in different banks and are read in the same cycle.
   logic [SIDE-1:0] rd_row   [2][3];
   logic [BAW-1:0]  rd_addr  [3];
   logic            wr_clear [2][3];
   logic            wr_en    [2][3];
   logic [BAW-1:0]  wr_addr  [2][3];
   logic [CAW-1:0]  wr_bit   [2][3];
   logic            wr_value [2][3];

   logic           clr_active_ff;
   logic [BAW-1:0] clr_addr_ff;
   logic           cur_sel_ff;

   logic           accept;
   logic           on_board;
   logic           yu_ok;
   logic           yd_ok;
   logic           xm_ok;
   logic           xp_ok;
   logic [1:0]     y_rem;
   logic [1:0]     up_bank;
   logic [BAW-1:0] y_quot;
   logic [CAW-1:0] x_col;
   logic           set_go;

   logic           st1_valid_ff;
   logic           st1_eval_ff;
   logic           st1_board_ff;
   logic [1:0]     st1_m_ff;
   logic [BAW-1:0] st1_q_ff;
   logic [CAW-1:0] st1_x_ff;
   logic           st1_xm_ok_ff;
   logic           st1_xp_ok_ff;
   logic           st1_yu_ok_ff;
   logic           st1_yd_ok_ff;

   logic [SIDE-1:0] cur_row [3];
   logic [SIDE-1:0] row_up;
   logic [SIDE-1:0] row_mid;
   logic [SIDE-1:0] row_dn;
   logic [CAW-1:0]  col_l;
   logic [CAW-1:0]  col_r;
   logic [2:0]      win_up;
   logic [2:0]      win_mid;
   logic [2:0]      win_dn;

   lcas_pkg::rsp_type rsp_in;
   lcas_pkg::rsp_type rsp_data_ff;
   logic              rsp_strobe_ff;

   assign busy   = clr_active_ff;
   assign accept = start && !clr_active_ff;

   // ---------------- request decode and bank addressing ----------------
   assign on_board = ({3'b000, req_data.cell_x} < SIDE_V) &&
                     ({3'b000, req_data.cell_y} < SIDE_V);
   assign xm_ok   = (req_data.cell_x != '0);
   assign xp_ok   = (({3'b000, req_data.cell_x} + 9'd1) < SIDE_V);
   assign yu_ok   = (req_data.cell_y != '0);
   assign yd_ok   = (({3'b000, req_data.cell_y} + 9'd1) < SIDE_V);
   assign y_rem   = lcas_pkg::rem3(req_data.cell_y);
   assign y_quot  = BAW'(lcas_pkg::quot3(req_data.cell_y));
   assign up_bank = lcas_pkg::dec3(y_rem);
   assign x_col   = CAW'(req_data.cell_x);
   assign set_go  = accept && (req_data.func == lcas_pkg::FUNC_SET) && on_board;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (!on_board) begin
            rd_addr[k] = '0;
         end else if (2'(k) == y_rem) begin
            rd_addr[k] = y_quot;
         end else if (2'(k) == up_bank) begin
            // The row above wraps to the previous bank row when the cell is in bank 0.
            rd_addr[k] = !yu_ok ? '0 : ((y_rem == 2'd0) ? y_quot - BAW'(1) : y_quot);
         end else begin
            rd_addr[k] = !yd_ok ? '0 : ((y_rem == 2'd2) ? y_quot + BAW'(1) : y_quot);
         end
      end
   end

   // ---------------- clearing pass and board select ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         cur_sel_ff    <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_addr_ff == LAST_ROW) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + BAW'(1);
            end
         end
         if (accept && (req_data.func == lcas_pkg::FUNC_SWAP)) begin
            cur_sel_ff <= !cur_sel_ff;
         end
      end
   end

   // ---------------- read stage registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st1_eval_ff  <= 1'b0;
      end else begin
         st1_valid_ff <= accept;
         st1_eval_ff  <= accept && (req_data.func == lcas_pkg::FUNC_EVAL) && on_board;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st1_board_ff <= cur_sel_ff;
         st1_m_ff     <= y_rem;
         st1_q_ff     <= y_quot;
         st1_x_ff     <= x_col;
         st1_xm_ok_ff <= xm_ok;
         st1_xp_ok_ff <= xp_ok;
         st1_yu_ok_ff <= yu_ok;
         st1_yd_ok_ff <= yd_ok;
      end
   end

   // ---------------- neighborhood window ----------------
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cur_row[k] = st1_board_ff ? rd_row[1][k] : rd_row[0][k];
      end
   end

   assign row_mid = cur_row[st1_m_ff];
   assign row_up  = cur_row[lcas_pkg::dec3(st1_m_ff)];
   assign row_dn  = cur_row[lcas_pkg::inc3(st1_m_ff)];
   assign col_l   = st1_x_ff - CAW'(1);
   assign col_r   = st1_x_ff + CAW'(1);

   assign win_mid = {row_mid[col_r] && st1_xp_ok_ff, row_mid[st1_x_ff],
                     row_mid[col_l] && st1_xm_ok_ff};
   assign win_up  = {row_up[col_r] && st1_xp_ok_ff, row_up[st1_x_ff],
                     row_up[col_l] && st1_xm_ok_ff} & {3{st1_yu_ok_ff}};
   assign win_dn  = {row_dn[col_r] && st1_xp_ok_ff, row_dn[st1_x_ff],
                     row_dn[col_l] && st1_xm_ok_ff} & {3{st1_yd_ok_ff}};

   lcas_eval u_eval (
      .enable  (st1_eval_ff),
      .win_up  (win_up),
      .win_mid (win_mid),
      .win_dn  (win_dn),
      .rsp     (rsp_in)
   );

   // ---------------- bank write ports ----------------
   // A set writes the current board at accept; an evaluate writes the other
   // board in the cycle after accept. Back-to-back transactions never hit the same board.
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         for (int k = 0; k < 3; k++) begin
            wr_clear[b][k] = clr_active_ff;
            wr_en[b][k]    = 1'b0;
            wr_addr[b][k]  = clr_addr_ff;
            wr_bit[b][k]   = x_col;
            wr_value[b][k] = 1'b1;
            priority if (clr_active_ff) begin
               wr_en[b][k] = 1'b0;
            end else if (set_go && (cur_sel_ff == 1'(b)) && (y_rem == 2'(k))) begin
               wr_en[b][k]   = 1'b1;
               wr_addr[b][k] = y_quot;
            end else if (st1_eval_ff && (st1_board_ff != 1'(b)) && (st1_m_ff == 2'(k))) begin
               wr_en[b][k]    = 1'b1;
               wr_addr[b][k]  = st1_q_ff;
               wr_bit[b][k]   = st1_x_ff;
               wr_value[b][k] = rsp_in.alive_next;
            end else begin
               wr_en[b][k] = 1'b0;
            end
         end
      end
   end

   for (genvar gb = 0; gb < 2; gb++) begin : g_board
      for (genvar gk = 0; gk < 3; gk++) begin : g_bank
         lcas_bank #(
            .SIDE  (SIDE),
            .DEPTH (DEPTH)
         ) u_bank (
            .clock    (clock),
            .wr_clear (wr_clear[gb][gk]),
            .wr_en    (wr_en[gb][gk]),
            .wr_addr  (wr_addr[gb][gk]),
            .wr_bit   (wr_bit[gb][gk]),
            .wr_value (wr_value[gb][gk]),
            .rd_en    (accept),
            .rd_addr  (rd_addr[gk]),
            .rd_data  (rd_row[gb][gk])
         );
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= st1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

### design/lcas_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcas_checker
// Port-level checks on the cell engine, bound to the top level.
// ----------------------------------------------------------------------------
module lcas_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire lcas_pkg::req_type req_data,
   input wire logic              rsp_strobe,
   input wire lcas_pkg::rsp_type rsp_data
);

   // Every accepted transaction produces its result through the read stage and result register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result without a matching transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without an accepted transaction");

   // Set, swap and unused selectors return all zeros.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && !busy && req_data.func != lcas_pkg::FUNC_EVAL, 2))
      |-> (rsp_data == '0))
      else $error("non-evaluate transaction returned a nonzero result");

   // A live successor needs two or three neighbors, and the count never exceeds eight.
   a_rule: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.neighbor_count <= lcas_pkg::MAX_COUNT) &&
                      (!rsp_data.alive_next ||
                       rsp_data.neighbor_count == lcas_pkg::SURVIVE_LOW ||
                       rsp_data.neighbor_count == lcas_pkg::BIRTH_COUNT)))
      else $error("result breaks the B3/S23 rule");

   // Once the clearing pass is over the block stays available.
   a_busy_once: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy rose outside reset");

endmodule

bind life_cell_automaton_step_top lcas_checker u_lcas_checker (.*);
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the B3/S23 cell engine. A directed table covers two
// opposite board corners, a fully surrounded cell, a swap and the unused selector. Then
// window-local set/evaluate/swap runs follow, with some random noise mixed in.
// Results are checked against the typed table entries or a bench-side model of both boards.
// ----------------------------------------------------------------------------
module tb;
   import lcas_pkg::*;

   localparam int         BOARD_SIDE  = SIDE_DEFAULT;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int         RANDOM_CELLS = 950;
   localparam int         STALL_LIMIT  = 3000;
   localparam int         WIN          = 6;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_t;

   typedef struct {
      req_type req;
      rsp_type rsp;
   } cell_result_t;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Bench copy of both boards; live_sel picks the current one.
   bit           board_cells [2][BOARD_SIDE][BOARD_SIDE];
   bit           live_sel;
   cell_result_t cell_results_q[$];
   stim_row_t    directed_rows[$];
   int           errors;
   int           idle_pct;
   int           quiet_cycles;
   int           win_x;
   int           win_y;

   life_cell_automaton_step_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies one transaction to the board copy and returns the expected result.
   function automatic rsp_type life_rule_step(req_type r);
      rsp_type o;
      int      x;
      int      y;
      int      nx;
      int      ny;
      int      n;
      bit      now;
      bit      nxt;
      o = '0;
      x = r.cell_x;
      y = r.cell_y;
      case (r.func)
         FUNC_SET: begin
            if (x < BOARD_SIDE && y < BOARD_SIDE) board_cells[live_sel][y][x] = 1'b1;
         end
         FUNC_EVAL: begin
            if (x < BOARD_SIDE && y < BOARD_SIDE) begin
               n = 0;
               for (int dy = -1; dy <= 1; dy++) begin
                  for (int dx = -1; dx <= 1; dx++) begin
                     nx = x + dx;
                     ny = y + dy;
                     if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
                         nx < BOARD_SIDE && ny < BOARD_SIDE)
                        n += board_cells[live_sel][ny][nx];
                  end
               end
               now = board_cells[live_sel][y][x];
               nxt = (n == BIRTH_COUNT) || (now && n == SURVIVE_LOW);
               board_cells[!live_sel][y][x] = nxt;
               o.alive_now      = now;
               o.alive_next     = nxt;
               o.neighbor_count = COUNT_W'(n);
            end
         end
         FUNC_SWAP: live_sel = !live_sel;
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type make_req(logic [1:0] f, int x, int y);
      req_type r;
      r.func   = f;
      r.cell_x = COORD_W'(x);
      r.cell_y = COORD_W'(y);
      return r;
   endfunction

   function automatic void add_row(logic [1:0] f, int x, int y, bit typed = 1'b0,
                                   bit now = 1'b0, bit nxt = 1'b0, int n = 0);
      stim_row_t row;
      row.req                = make_req(f, x, y);
      row.typed              = typed;
      row.rsp.alive_now      = now;
      row.rsp.alive_next     = nxt;
      row.rsp.neighbor_count = COUNT_W'(n);
      directed_rows.push_back(row);
   endfunction

   function automatic req_type window_req(logic [1:0] f);
      return make_req(f, win_x + $urandom_range(WIN - 1), win_y + $urandom_range(WIN - 1));
   endfunction

   function automatic int window_base();
      case ($urandom_range(3))
         0: return 0;
         1: return BOARD_SIDE - WIN;
         default: return $urandom_range(BOARD_SIDE - WIN);
      endcase
   endfunction

   // Presents one transaction from the falling edge and returns at the edge
   // where it is taken. The request stays up so back-to-back items need no
   // second assignment to start in the same step.
   task automatic send_cell(req_type r, bit typed = 1'b0, rsp_type typed_rsp = '0);
      cell_result_t c;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      c.req = r;
      c.rsp = life_rule_step(r);
      if (typed) c.rsp = typed_rsp;
      cell_results_q.push_back(c);
   endtask

   always @(posedge clock) begin
      cell_result_t c;
      if (!reset && rsp_strobe === 1'b1) begin
         if (cell_results_q.size() == 0) begin
            $display("%0t: unexpected result now=%0b next=%0b count=%0d", $time,
                     rsp_data.alive_now, rsp_data.alive_next, rsp_data.neighbor_count);
            errors++;
         end else begin
            c = cell_results_q.pop_front();
            if (rsp_data.alive_now !== c.rsp.alive_now ||
                rsp_data.alive_next !== c.rsp.alive_next ||
                rsp_data.neighbor_count !== c.rsp.neighbor_count) begin
               $display("%0t: func=%0d x=%0d y=%0d expected now=%0b next=%0b count=%0d, %s",
                        $time, c.req.func, c.req.cell_x, c.req.cell_y, c.rsp.alive_now,
                        c.rsp.alive_next, c.rsp.neighbor_count, "actual follows");
               $display("%0t:    actual now=%0b next=%0b count=%0d", $time,
                        rsp_data.alive_now, rsp_data.alive_next, rsp_data.neighbor_count);
               errors++;
            end
         end
      end
   end

   // Watchdog: any cycle without an accepted request or result counts toward the limit.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[life_cell_automaton_step_top] ERROR");
         $finish;
      end
   end

   initial begin : main
      int idle_plan [4];
      int cells_sent;
      int sets;
      int evals;
      req_type r;
      idle_plan    = '{0, 77, 0, 36};
      clock        = 1'b0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      errors       = 0;
      idle_pct     = 0;
      quiet_cycles = 0;
      live_sel     = 1'b0;
      cells_sent   = 0;

      // Fresh boards read back all dead; set and swap always return zeros.
      add_row(FUNC_EVAL, 0, 0, 1);
      add_row(FUNC_EVAL, 63, 63, 1);
      add_row(FUNC_SET, 0, 0, 1);
      add_row(FUNC_SET, 1, 0, 1);
      add_row(FUNC_SET, 0, 1, 1);
      add_row(FUNC_EVAL, 1, 1);
      add_row(FUNC_EVAL, 0, 0);
      add_row(FUNC_SET, 63, 63, 1);
      add_row(FUNC_SET, 62, 63, 1);
      add_row(FUNC_SET, 63, 62, 1);
      add_row(FUNC_SET, 62, 62, 1);
      add_row(FUNC_EVAL, 63, 63);
      add_row(FUNC_EVAL, 62, 62);
      // Surround a dead interior cell completely: eight neighbors, stays dead.
      for (int dy = -1; dy <= 1; dy++)
         for (int dx = -1; dx <= 1; dx++)
            if (dx != 0 || dy != 0) add_row(FUNC_SET, 32 + dx, 32 + dy, 1);
      add_row(FUNC_EVAL, 32, 32);
      add_row(FUNC_UNUSED, 63, 63, 1);
      add_row(FUNC_SWAP, 17, 42, 1);
      add_row(FUNC_EVAL, 1, 1);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_cell(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

      // Most traffic seeds a small window and then evaluates it, so cells see
      // real neighborhoods; occasional swaps promote the evaluated generation.
      while (cells_sent < RANDOM_CELLS) begin
         idle_pct = idle_plan[(cells_sent / 240) % 4];
         if ($urandom_range(9) == 0) begin
            r.func   = 2'($urandom_range(3));
            r.cell_x = COORD_W'($urandom_range(63));
            r.cell_y = COORD_W'($urandom_range(63));
            send_cell(r);
            if (r.func != FUNC_UNUSED) cells_sent++;
         end else begin
            win_x = window_base();
            win_y = window_base();
            sets  = $urandom_range(10, 2);
            evals = $urandom_range(20, 6);
            repeat (sets) send_cell(window_req(FUNC_SET));
            repeat (evals) send_cell(window_req(FUNC_EVAL));
            cells_sent += sets + evals;
            if ($urandom_range(2) == 0) begin
               send_cell(window_req(FUNC_SWAP));
               repeat (evals) send_cell(window_req(FUNC_EVAL));
               cells_sent += evals + 1;
            end
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (cell_results_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("[life_cell_automaton_step_top] OK");
      else
         $display("[life_cell_automaton_step_top] ERROR");
      $finish;
   end

endmodule
